// ===== hdl/ngm_pkg.sv =====
// ----------------------------------------------------------------------------
// ngm_pkg
// shared types and constants of the nearest glyph match unit
// ----------------------------------------------------------------------------
`default_nettype none
package ngm_pkg;
   localparam int TableDepthDefault  = 128;
   localparam int DensityBitsDefault = 8;
   localparam int Lanes              = 8;
   localparam int DensW              = 8;
   localparam int GlyphW             = 16;
   localparam int IndexW             = 7;
   localparam int DistW              = 19;
   localparam logic [GlyphW-1:0] SpaceCode = 16'd32;
   localparam logic [DistW-1:0]  DistMax   = 19'h7FFFF;

   typedef enum logic {FUNC_LOAD = 1'b0, FUNC_QUERY = 1'b1} func_type;

   typedef struct packed {
      func_type                     func;
      logic [Lanes-1:0][DensW-1:0]  dens;
      logic [GlyphW-1:0]            glyph_in;
   } req_type;

   typedef struct packed {
      logic [GlyphW-1:0] glyph_out;
      logic [IndexW-1:0] best_index;
      logic [DistW-1:0]  best_distance;
      logic              found;
      logic              load_dropped;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hdl/ngm_if.sv =====
// ----------------------------------------------------------------------------
// ngm_req_if / ngm_rsp_if
// valid/ready channels of the nearest glyph match unit
// ----------------------------------------------------------------------------
`default_nettype none
interface ngm_req_if;
   logic             valid;
   logic             ready;
   ngm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ngm_rsp_if;
   logic             valid;
   logic             ready;
   ngm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/nearest_glyph_match_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_glyph_match_unit
// nearest glyph table match by squared euclidean distance
//
// req channel: func 0 appends a glyph entry (dropped and flagged when the
// table is full), func 1 queries one 4x2 block of densities.
// rsp channel: exactly one result per item, in order.
// a load result is registered when the load leaves the front queue; a query
// result follows a scan of all entries, with the table memory read
// port supplying one entry per cycle to the distance pipeline.
// a two-entry front queue keeps accepting while the scan runs.
// reset clears the entry count and all control state; the table contents
// are undefined but never used before written.
// a stalled rsp holds its result and the back end waits; the front queue
// fills and then drops req.ready.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_glyph_match_unit #(
   parameter int TableDepth  = ngm_pkg::TableDepthDefault,
   parameter int DensityBits = ngm_pkg::DensityBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   ngm_req_if.sink   req,
   ngm_rsp_if.source rsp
);
   ngm_pkg::req_type q_data;
   logic             q_valid, q_pop;

   ngm_front #(.DensityBits(DensityBits)) u_front (
      .clock, .reset, .req, .q_data, .q_valid, .q_pop);

   ngm_back #(.TableDepth(TableDepth)) u_back (
      .clock, .reset, .q_data, .q_valid, .q_pop, .rsp);
endmodule
`default_nettype wire

// ===== hdl/ngm_front.sv =====
// ----------------------------------------------------------------------------
// ngm_front
// accepts items into a two-entry queue, lane values masked to density width
// ----------------------------------------------------------------------------
`default_nettype none
module ngm_front #(
   parameter int DensityBits = ngm_pkg::DensityBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ngm_req_if.sink          req,
   output ngm_pkg::req_type q_data,
   output logic             q_valid,
   input  wire logic        q_pop
);
   localparam int UseBits = (DensityBits < ngm_pkg::DensW) ? DensityBits : ngm_pkg::DensW;
   localparam logic [ngm_pkg::DensW-1:0] Mask = ngm_pkg::DensW'((1 << UseBits) - 1);

   ngm_pkg::req_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   ngm_pkg::req_type item;
   logic push;

   always_comb begin
      item = req.data;
      for (int l = 0; l < ngm_pkg::Lanes; l++) item.dens[l] = req.data.dens[l] & Mask;
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= item;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req.ready) else $error("ready while full");
endmodule
`default_nettype wire

// ===== hdl/ngm_back.sv =====
// ----------------------------------------------------------------------------
// ngm_back
// table store and one-entry-per-cycle distance scan
// ----------------------------------------------------------------------------
`default_nettype none
module ngm_back #(
   parameter int TableDepth = ngm_pkg::TableDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  ngm_pkg::req_type q_data,
   input  wire logic        q_valid,
   output logic             q_pop,
   ngm_rsp_if.source        rsp
);
   localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int CW = $clog2(TableDepth + 1);
   localparam int SqW = 2 * ngm_pkg::DensW;
   localparam int SumW = SqW + 3;
   localparam logic [CW-1:0] Full = CW'(TableDepth);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_READ = 4'b0010, S_SCAN = 4'b0100, S_OUT = 4'b1000
   } state_type;

   logic [ngm_pkg::Lanes*ngm_pkg::DensW-1:0] dens_mem [TableDepth];
   logic [ngm_pkg::GlyphW-1:0]               glyph_mem [TableDepth];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] rd_ff;          // address being read this cycle
   logic [AW-1:0] idx_ff;         // index of the data now in rdata
   logic          rvalid_ff;
   logic [ngm_pkg::Lanes*ngm_pkg::DensW-1:0] rdata_ff;
   logic [ngm_pkg::GlyphW-1:0] gdata_ff;
   logic [ngm_pkg::Lanes-1:0][SqW-1:0] sq_ff;
   logic          sqv_ff;
   logic [AW-1:0] sqi_ff;
   logic [ngm_pkg::GlyphW-1:0] sqg_ff;
   logic [SumW-1:0] best_d_ff;
   logic [AW-1:0]   best_i_ff;
   logic [ngm_pkg::GlyphW-1:0] best_g_ff;
   logic            have_ff;
   logic            rsp_valid_ff;
   ngm_pkg::rsp_type rsp_ff;
   logic [SumW-1:0] sum;
   logic            scan_done;
   logic [AW-1:0]   rd_addr;

   assign rd_addr = rd_ff[AW-1:0];

   always_comb begin
      sum = '0;
      for (int l = 0; l < ngm_pkg::Lanes; l++) sum = sum + SumW'(sq_ff[l]);
   end

   assign scan_done = (rd_ff == count_ff) && !rvalid_ff && !sqv_ff;
   assign q_pop = (state_ff == S_IDLE && q_valid && !rsp_valid_ff
                     && q_data.func == ngm_pkg::FUNC_LOAD)
               || (state_ff == S_OUT && !rsp_valid_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_valid && !rsp_valid_ff && q_data.func == ngm_pkg::FUNC_QUERY)
                    state_in = (count_ff == '0) ? S_OUT : S_SCAN;
         S_SCAN: if (scan_done) state_in = S_OUT;
         S_OUT:  if (!rsp_valid_ff) state_in = S_IDLE;
         S_READ: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid && !rsp_valid_ff
          && q_data.func == ngm_pkg::FUNC_LOAD && count_ff != Full) begin
         dens_mem[count_ff[AW-1:0]]  <= q_data.dens;
         glyph_mem[count_ff[AW-1:0]] <= q_data.glyph_in;
      end
      rdata_ff <= dens_mem[rd_addr];
      gdata_ff <= glyph_mem[rd_addr];
      idx_ff   <= rd_addr;
      for (int l = 0; l < ngm_pkg::Lanes; l++) begin
         logic [ngm_pkg::DensW-1:0] a, b, d;
         a = q_data.dens[l];
         b = rdata_ff[l*ngm_pkg::DensW +: ngm_pkg::DensW];
         d = (a >= b) ? a - b : b - a;
         sq_ff[l] <= d * d;
      end
      sqi_ff <= idx_ff;
      sqg_ff <= gdata_ff;
      if (q_pop) begin
         if (q_data.func == ngm_pkg::FUNC_LOAD) begin
            rsp_ff.glyph_out     <= '0;
            rsp_ff.best_index    <= '0;
            rsp_ff.best_distance <= '0;
            rsp_ff.found         <= 1'b0;
            rsp_ff.load_dropped  <= (count_ff == Full);
         end else begin
            rsp_ff.glyph_out     <= have_ff ? best_g_ff : ngm_pkg::SpaceCode;
            rsp_ff.best_index    <= have_ff ? ngm_pkg::IndexW'(best_i_ff) : '0;
            rsp_ff.best_distance <= !have_ff ? '0 :
               (best_d_ff > SumW'(ngm_pkg::DistMax)) ? ngm_pkg::DistMax
                                                     : ngm_pkg::DistW'(best_d_ff);
            rsp_ff.found         <= have_ff;
            rsp_ff.load_dropped  <= 1'b0;
         end
      end
      if (sqv_ff && (!have_ff || sum < best_d_ff)) begin
         best_d_ff <= sum; best_i_ff <= sqi_ff; best_g_ff <= sqg_ff;
      end
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rd_ff <= '0; rvalid_ff <= 1'b0;
         sqv_ff <= 1'b0; have_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_data.func == ngm_pkg::FUNC_LOAD && count_ff != Full)
            count_ff <= count_ff + 1'b1;
         rvalid_ff <= (state_ff == S_SCAN) && (rd_ff != count_ff);
         if (state_ff == S_SCAN && rd_ff != count_ff) rd_ff <= rd_ff + 1'b1;
         else if (state_ff != S_SCAN) rd_ff <= '0;
         sqv_ff <= rvalid_ff;
         if (state_ff == S_IDLE) have_ff <= 1'b0;
         else if (sqv_ff) have_ff <= 1'b1;
         if (q_pop) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full) else $error("entry count beyond depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff) else $error("result lost");
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid_ff) else $error("pop while result pending");
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench of the nearest glyph match unit
//
// loads glyph entries and queries 4x2 density blocks over valid/ready
// channels with random sender bursts and receiver stalls. a scoreboard keeps
// its own copy of the glyph table, predicts each result and compares it field
// by field in order. the table is filled to capacity and overloaded; the
// unit is reset only once, at start.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth     = ngm_pkg::TableDepthDefault;
   localparam int IdleLimit = 20000;

   class glyph_scoreboard;
      logic [ngm_pkg::Lanes-1:0][ngm_pkg::DensW-1:0] tbl_dens[Depth];
      logic [ngm_pkg::GlyphW-1:0]                    tbl_glyph[Depth];
      int                                            fill;
      ngm_pkg::rsp_type                              pending[$];
      int                                            mismatches;
      int                                            checked;
      int                                            queries;
      int                                            drops;

      function void note_item(ngm_pkg::req_type r);
         ngm_pkg::rsp_type e;
         int      best;
         longint  best_d;
         longint  d;
         int      diff;
         e = '0;
         if (r.func == ngm_pkg::FUNC_LOAD) begin
            if (fill >= Depth) begin
               e.load_dropped = 1'b1;
               drops++;
            end else begin
               tbl_dens[fill] = r.dens;
               tbl_glyph[fill] = r.glyph_in;
               fill++;
            end
         end else if (fill == 0) begin
            e.glyph_out = ngm_pkg::SpaceCode;
            queries++;
         end else begin
            best = 0;
            best_d = -1;
            for (int k = 0; k < fill; k++) begin
               d = 0;
               for (int l = 0; l < ngm_pkg::Lanes; l++) begin
                  diff = int'(r.dens[l]) - int'(tbl_dens[k][l]);
                  d += diff * diff;
               end
               if (best_d < 0 || d < best_d) begin
                  best_d = d;
                  best = k;
               end
            end
            e.glyph_out = tbl_glyph[best];
            e.best_index = best[ngm_pkg::IndexW-1:0];
            e.best_distance = (best_d > ngm_pkg::DistMax) ? ngm_pkg::DistMax
                                                          : best_d[ngm_pkg::DistW-1:0];
            e.found = 1'b1;
            queries++;
         end
         pending.insert(pending.size(), e);
      endfunction

      function void check_result(ngm_pkg::rsp_type a);
         ngm_pkg::rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", a);
            return;
         end
         e = pending.pop_front();
         if (a.glyph_out !== e.glyph_out || a.best_index !== e.best_index ||
             a.best_distance !== e.best_distance || a.found !== e.found ||
             a.load_dropped !== e.load_dropped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: expected %p got %p", checked, e, a);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   ngm_req_if req ();
   ngm_rsp_if rsp ();
   glyph_scoreboard board = new();
   int  idle_cycles = 0;
   int  stall_mode = 0;
   bit  stim_done = 1'b0;

   nearest_glyph_match_unit uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #2 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_item(req.data);
         if (rsp.valid && rsp.ready) board.check_result(rsp.data);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver stall pattern changes now and then
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         2: rsp.ready <= ($urandom_range(0, 3) == 0);
         default: rsp.ready <= ($urandom_range(0, 15) < 8);
      endcase
   end

   task automatic send_item(ngm_pkg::req_type r);
      req.data <= r;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic ngm_pkg::req_type make_item(ngm_pkg::func_type f, int mode);
      ngm_pkg::req_type r;
      r.func = f;
      r.glyph_in = 16'($urandom());
      for (int l = 0; l < ngm_pkg::Lanes; l++) begin
         case (mode)
            0: r.dens[l] = 8'h00;
            1: r.dens[l] = 8'hFF;
            2: r.dens[l] = l[0] ? 8'hFF : 8'h00;
            default: r.dens[l] = 8'($urandom());
         endcase
      end
      return r;
   endfunction

   function automatic ngm_pkg::req_type near_item(int k, int spread);
      ngm_pkg::req_type r;
      int      v;
      r = make_item(ngm_pkg::FUNC_QUERY, 3);
      for (int l = 0; l < ngm_pkg::Lanes; l++) begin
         v = int'(board.tbl_dens[k][l]) + $urandom_range(0, 2 * spread) - spread;
         r.dens[l] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : 8'(v);
      end
      return r;
   endfunction

   task automatic random_items(int n, int load_pct);
      int     burst;
      ngm_pkg::req_type r;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
         end
         burst--;
         if ($urandom_range(0, 99) < load_pct) begin
            r = make_item(ngm_pkg::FUNC_LOAD,
                          $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
         end else if (board.fill > 0 && $urandom_range(0, 1) == 0) begin
            r = near_item($urandom_range(0, board.fill - 1), $urandom_range(0, 6));
         end else begin
            r = make_item(ngm_pkg::FUNC_QUERY,
                          $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
         end
         send_item(r);
      end
   endtask

   initial begin
      ngm_pkg::req_type r;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, then extremes and ties
      send_item(make_item(ngm_pkg::FUNC_QUERY, 0));
      send_item(make_item(ngm_pkg::FUNC_QUERY, 1));
      r = make_item(ngm_pkg::FUNC_LOAD, 0);
      r.glyph_in = 16'hFFFF;
      send_item(r);
      r = make_item(ngm_pkg::FUNC_LOAD, 1);
      r.glyph_in = 16'h0000;
      send_item(r);
      r = make_item(ngm_pkg::FUNC_LOAD, 0);
      r.glyph_in = 16'h1234;
      send_item(r);
      send_item(make_item(ngm_pkg::FUNC_QUERY, 0));
      send_item(make_item(ngm_pkg::FUNC_QUERY, 1));
      send_item(make_item(ngm_pkg::FUNC_QUERY, 2));
      r = make_item(ngm_pkg::FUNC_LOAD, 2);
      r.glyph_in = 16'h5555;
      send_item(r);
      send_item(make_item(ngm_pkg::FUNC_QUERY, 2));
      r = make_item(ngm_pkg::FUNC_QUERY, 2);
      r.dens = ~r.dens;
      send_item(r);
      wait_drained();

      // random fill with queries, up to full table
      random_items(300, 45);
      wait_drained();
      while (board.fill < Depth) send_item(make_item(ngm_pkg::FUNC_LOAD, 3));
      // loads into a full table are dropped
      for (int i = 0; i < 6; i++) send_item(make_item(ngm_pkg::FUNC_LOAD, i % 3));
      send_item(make_item(ngm_pkg::FUNC_QUERY, 0));
      send_item(make_item(ngm_pkg::FUNC_QUERY, 1));
      random_items(1100, 10);

      wait_drained();
      repeat (200) @(negedge clock);
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      $display("covered %0d results: %0d queries and %0d dropped loads, table filled to %0d",
               board.checked, board.queries, board.drops, board.fill);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/ngm_pkg.sv
hdl/ngm_if.sv
hdl/ngm_front.sv
hdl/ngm_back.sv
hdl/nearest_glyph_match_unit.sv
verif/tb_top.sv
